// ===== design/cic_pkg.sv =====
`timescale 1ns / 1ps

package cic_pkg;

    localparam int ASSERT_COUNT_BITS = 4;

    localparam logic [2:0] KIND_WRITE    = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_ASSERT   = 3'd2;
    localparam logic [2:0] KIND_DEASSERT = 3'd3;
    localparam logic [2:0] KIND_PULSE    = 3'd4;
    localparam logic [2:0] KIND_ACK      = 3'd5;

    localparam logic [1:0] TGT_MASTER = 2'd0;
    localparam logic [1:0] TGT_SLAVE  = 2'd1;
    localparam logic [1:0] TGT_ELCR   = 2'd2;

    localparam logic [7:0] ELCR_MASK_M = 8'hf8;
    localparam logic [7:0] ELCR_MASK_S = 8'hde;
    localparam logic [7:0] POLL_FLAG   = 8'h80;
    localparam logic [7:0] BASE_MASK   = 8'hf8;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] target;
        logic       port_offset;
        logic [2:0] access_width;
        logic [7:0] write_data;
        logic [3:0] irq_line;
        logic [7:0] ack_vector;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
        logic       cpu_notify;
        logic       pending_valid;
        logic [7:0] pending_vector;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic execute;
        logic resolve;
    } t_cmd;

    // Top request search: returns found bit and pin.
    function automatic logic [3:0] top_request(
        input logic [7:0] irr, input logic [7:0] isr, input logic [7:0] imr,
        input logic [2:0] low, input logic sfnm, input logic smm);
        logic [7:0] busy;
        logic [2:0] p;
        logic       stop;
        logic [3:0] res;
        busy = isr;
        if (sfnm) busy[2] = 1'b0;
        if (smm) busy = 8'h00;
        res  = 4'd0;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
            p = low + 3'(k + 1);
            if (!stop) begin
                if (busy[p]) begin
                    stop = 1'b1;
                end else if (irr[p] && !imr[p]) begin
                    res  = {1'b1, p};
                    stop = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] top_service(
        input logic [7:0] isr, input logic [7:0] imr, input logic [2:0] low,
        input logic smm);
        logic [2:0] p;
        logic [3:0] res;
        res = 4'd0;
        for (int k = 7; k >= 0; k--) begin
            p = low + 3'(k + 1);
            if (isr[p] && !(smm && imr[p])) res = {1'b1, p};
        end
        return res;
    endfunction

endpackage

// ===== design/cic_if.sv =====
`timescale 1ns / 1ps

interface cic_in_if;
    logic             valid;
    logic             ready;
    cic_pkg::t_in     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cic_out_if;
    logic             valid;
    logic             ready;
    cic_pkg::t_out    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cic_ctrl.sv =====
`timescale 1ns / 1ps

module cic_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cic_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RES  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Idle takes an item, resolve computes the result, out holds it.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_RES;
            S_RES:  n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = i_in_valid ? S_RES : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_in_ready    = (r_state == S_IDLE) || (r_state == S_OUT && i_out_ready);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.execute = o_in_ready && i_in_valid;
    assign o_cmd.resolve = (r_state == S_RES);

endmodule

// ===== design/cic_dp.sv =====
`timescale 1ns / 1ps

module cic_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cic_pkg::t_cmd  i_cmd,
    input  cic_pkg::t_in   i_item,
    output cic_pkg::t_out  o_result
);

    localparam int CB = cic_pkg::ASSERT_COUNT_BITS;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [CB-1:0] CONE = CB'(1);

    typedef struct packed {
        logic       pv;
        logic [7:0] vec;
    } t_out_hold;

    // Outcome of one raise check on both controllers.
    typedef struct packed {
        logic [1:0]    raised;
        logic          irr2;
        logic [CB-1:0] cnt2;
        logic          notify;
    } t_eval;

    logic [2:0] r_step [2];
    logic [1:0] r_rdy, r_ris, r_aeoi, r_poll, r_rot, r_sfnm, r_smm, r_raised;
    logic [7:0] r_base [2];
    logic [7:0] r_irr [2];
    logic [7:0] r_isr [2];
    logic [7:0] r_imr [2];
    logic [2:0] r_low [2];
    logic [7:0] r_elcr [2];
    logic [CB-1:0] r_cnt [16];
    logic [7:0] r_rd;
    logic       r_st, r_notify;
    t_out_hold  r_hold;

    logic [2:0] n_step [2];
    logic [1:0] n_rdy, n_ris, n_aeoi, n_poll, n_rot, n_sfnm, n_smm, n_raised;
    logic [7:0] n_base [2];
    logic [7:0] n_irr [2];
    logic [7:0] n_isr [2];
    logic [7:0] n_imr [2];
    logic [2:0] n_low [2];
    logic [7:0] n_elcr [2];
    logic [CB-1:0] n_cnt [16];
    logic [7:0] n_rd;
    logic       n_st, n_notify;

    // Raise check: a new slave raise cascades as a pulse on master pin 2,
    // then the master raises toward the CPU if it has an eligible request.
    function automatic t_eval evaluate(
        input logic [7:0] irr0, input logic [7:0] irr1,
        input logic [7:0] isr0, input logic [7:0] isr1,
        input logic [7:0] imr0, input logic [7:0] imr1,
        input logic [2:0] low0, input logic [2:0] low1,
        input logic [1:0] sfnm, input logic [1:0] smm, input logic [1:0] raised,
        input logic [CB-1:0] cnt2, input logic lvl2);
        t_eval         res;
        logic [3:0]    t;
        logic [7:0]    m_irr;
        logic [CB-1:0] b2, a2;
        res.raised = raised;
        res.irr2   = irr0[2];
        res.cnt2   = cnt2;
        res.notify = 1'b0;
        m_irr = irr0;
        t = cic_pkg::top_request(irr1, isr1, imr1, low1, sfnm[1], smm[1]);
        if (!raised[1] && t[3]) begin
            res.raised[1] = 1'b1;
            b2 = cnt2;
            a2 = (b2 != CMAX) ? b2 + CONE : b2;
            if ((b2 == '0 && a2 == CONE) || (a2 != '0 && lvl2)) res.irr2 = 1'b1;
            b2 = a2;
            a2 = (b2 != '0) ? b2 - CONE : b2;
            if (a2 != '0 && lvl2) res.irr2 = 1'b1;
            else if (b2 == CONE && a2 == '0 && lvl2) res.irr2 = 1'b0;
            res.cnt2 = a2;
            m_irr[2] = res.irr2;
        end
        t = cic_pkg::top_request(m_irr, isr0, imr0, low0, sfnm[0], smm[0]);
        if (!raised[0] && t[3]) begin
            res.raised[0] = 1'b1;
            res.notify    = 1'b1;
        end
        return res;
    endfunction

    // Applies one transaction to the whole register state.
    always_comb begin
        logic       c;
        logic [7:0] v;
        logic [3:0] t;
        logic [2:0] s;
        logic       hit;
        logic [2:0] ap;
        logic       evl;
        t_eval      e;
        n_step = r_step; n_rdy = r_rdy; n_ris = r_ris; n_aeoi = r_aeoi;
        n_poll = r_poll; n_rot = r_rot; n_sfnm = r_sfnm; n_smm = r_smm;
        n_raised = r_raised; n_base = r_base; n_irr = r_irr; n_isr = r_isr;
        n_imr = r_imr; n_low = r_low; n_elcr = r_elcr; n_cnt = r_cnt;
        n_rd = 8'd0; n_st = 1'b0; n_notify = 1'b0;
        c = i_item.target[0];
        v = i_item.write_data;
        evl = 1'b0;
        t = 4'd0; s = 3'd0; hit = 1'b0; ap = 3'd0;
        e = '0;
        case (i_item.kind)
            cic_pkg::KIND_WRITE, cic_pkg::KIND_READ: begin
                if (i_item.access_width != 3'd1 || i_item.target == 2'd3) begin
                    n_st = 1'b1;
                end else if (i_item.target == cic_pkg::TGT_ELCR) begin
                    if (i_item.kind == cic_pkg::KIND_READ)
                        n_rd = r_elcr[i_item.port_offset];
                    else
                        n_elcr[i_item.port_offset] = v & (i_item.port_offset ?
                            cic_pkg::ELCR_MASK_S : cic_pkg::ELCR_MASK_M);
                end else if (i_item.kind == cic_pkg::KIND_READ) begin
                    if (r_poll[c]) begin
                        n_poll[c] = 1'b0;
                        t = cic_pkg::top_request(r_irr[c], r_isr[c], r_imr[c],
                            r_low[c], r_sfnm[c], r_smm[c]);
                        if (t[3]) begin
                            n_rd = cic_pkg::POLL_FLAG | {5'd0, t[2:0]};
                            n_raised[c] = 1'b0;
                            if (!r_elcr[c][t[2:0]]) n_irr[c][t[2:0]] = 1'b0;
                            if (r_aeoi[c]) begin
                                if (r_rot[c]) n_low[c] = t[2:0];
                            end else begin
                                n_isr[c][t[2:0]] = 1'b1;
                            end
                        end
                    end else if (i_item.port_offset) begin
                        n_rd = r_imr[c];
                    end else begin
                        n_rd = r_ris[c] ? r_isr[c] : r_irr[c];
                    end
                end else begin
                    if (i_item.port_offset) begin
                        case (r_step[c])
                            3'd2: begin n_base[c] = v & cic_pkg::BASE_MASK;
                                n_step[c] = 3'd3; end
                            3'd3: n_step[c] = 3'd4;
                            3'd4: begin
                                if (!v[0]) n_st = 1'b1;
                                else begin
                                    n_aeoi[c] = v[1];
                                    n_sfnm[c] = !c && v[4];
                                    n_step[c] = 3'd0;
                                    n_rdy[c] = 1'b1;
                                end
                            end
                            default: n_imr[c] = v;
                        endcase
                    end else begin
                        if (v[4]) begin
                            n_rdy[c] = 1'b0; n_step[c] = 3'd1; n_irr[c] = 8'd0;
                            n_imr[c] = 8'd0; n_low[c] = 3'd7; n_ris[c] = 1'b0;
                            n_poll[c] = 1'b0; n_smm[c] = 1'b0;
                            if (v[1] || !v[0]) n_st = 1'b1;
                            else n_step[c] = 3'd2;
                        end
                        if (n_rdy[c]) begin
                            if (v[3]) begin
                                if (v[6]) n_smm[c] = v[5];
                                if (v[1]) begin
                                    n_ris[c] = v[0];
                                    n_poll[c] = v[2];
                                end
                            end else begin
                                n_rot[c] = v[7];
                                if (v[5]) begin
                                    t = cic_pkg::top_service(n_isr[c], n_imr[c],
                                        n_low[c], n_smm[c]);
                                    hit = v[6] || t[3];
                                    s = v[6] ? v[2:0] : t[2:0];
                                    if (hit) begin
                                        n_isr[c][s] = 1'b0;
                                        if (v[7]) n_low[c] = s;
                                    end
                                end else if (v[6] && v[7]) begin
                                    n_low[c] = v[2:0];
                                end
                            end
                        end
                    end
                    evl = n_rdy[c];
                end
            end
            cic_pkg::KIND_ASSERT, cic_pkg::KIND_DEASSERT, cic_pkg::KIND_PULSE: begin
                if (r_rdy[i_item.irq_line[3]]) begin
                    logic [CB-1:0] b4, a4;
                    logic lc, lv;
                    lc = i_item.irq_line[3];
                    lv = r_elcr[lc][i_item.irq_line[2:0]];
                    // Assert half of the event; a pulse checks for a raise here.
                    if (i_item.kind != cic_pkg::KIND_DEASSERT) begin
                        b4 = n_cnt[i_item.irq_line];
                        a4 = (b4 != CMAX) ? b4 + CONE : b4;
                        if ((b4 == '0 && a4 == CONE) || (a4 != '0 && lv))
                            n_irr[lc][i_item.irq_line[2:0]] = 1'b1;
                        n_cnt[i_item.irq_line] = a4;
                        if (i_item.kind == cic_pkg::KIND_PULSE) begin
                            e = evaluate(n_irr[0], n_irr[1], n_isr[0], n_isr[1],
                                n_imr[0], n_imr[1], n_low[0], n_low[1], n_sfnm,
                                n_smm, n_raised, n_cnt[2], r_elcr[0][2]);
                            n_raised = e.raised;
                            n_irr[0][2] = e.irr2;
                            n_cnt[2] = e.cnt2;
                            if (e.notify) n_notify = 1'b1;
                        end
                    end
                    // Deassert half of the event.
                    if (i_item.kind != cic_pkg::KIND_ASSERT) begin
                        b4 = n_cnt[i_item.irq_line];
                        a4 = (b4 != '0) ? b4 - CONE : b4;
                        if (a4 != '0 && lv)
                            n_irr[lc][i_item.irq_line[2:0]] = 1'b1;
                        else if (b4 == CONE && a4 == '0 && lv)
                            n_irr[lc][i_item.irq_line[2:0]] = 1'b0;
                        n_cnt[i_item.irq_line] = a4;
                    end
                    evl = 1'b1;
                end
            end
            cic_pkg::KIND_ACK: begin
                ap = i_item.ack_vector[2:0];
                if ((i_item.ack_vector & cic_pkg::BASE_MASK) == r_base[1]) begin
                    n_raised[1] = 1'b0;
                    if (!r_elcr[1][ap]) n_irr[1][ap] = 1'b0;
                    if (r_aeoi[1]) begin
                        if (r_rot[1]) n_low[1] = ap;
                    end else n_isr[1][ap] = 1'b1;
                    ap = 3'd2;
                end
                n_raised[0] = 1'b0;
                if (!r_elcr[0][ap]) n_irr[0][ap] = 1'b0;
                if (r_aeoi[0]) begin
                    if (r_rot[0]) n_low[0] = ap;
                end else n_isr[0][ap] = 1'b1;
                evl = 1'b1;
            end
            default: ;
        endcase
        // Final raise check after the transaction.
        if (evl) begin
            e = evaluate(n_irr[0], n_irr[1], n_isr[0], n_isr[1], n_imr[0],
                n_imr[1], n_low[0], n_low[1], n_sfnm, n_smm, n_raised, n_cnt[2],
                r_elcr[0][2]);
            n_raised = e.raised;
            n_irr[0][2] = e.irr2;
            n_cnt[2] = e.cnt2;
            if (e.notify) n_notify = 1'b1;
        end
    end

    // Resolve state: master then slave priority resolution.
    logic [3:0] w_m, w_s;
    t_out_hold  n_hold;
    always_comb begin
        w_m = cic_pkg::top_request(r_irr[0], r_isr[0], r_imr[0], r_low[0],
            r_sfnm[0], r_smm[0]);
        w_s = cic_pkg::top_request(r_irr[1], r_isr[1], r_imr[1], r_low[1],
            r_sfnm[1], r_smm[1]);
        n_hold = '0;
        if (w_m[3] && w_m[2:0] == 3'd2) begin
            n_hold.pv = w_s[3];
            if (w_s[3]) n_hold.vec = r_base[1] + {5'd0, w_s[2:0]};
        end else if (w_m[3]) begin
            n_hold.pv = 1'b1;
            n_hold.vec = r_base[0] + {5'd0, w_m[2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_step[i] <= 3'd0; r_base[i] <= 8'd0; r_irr[i] <= 8'd0;
                r_isr[i] <= 8'd0; r_imr[i] <= 8'hff; r_low[i] <= 3'd0;
                r_elcr[i] <= 8'd0;
            end
            r_rdy <= '0; r_ris <= '0; r_aeoi <= '0; r_poll <= '0; r_rot <= '0;
            r_sfnm <= '0; r_smm <= '0; r_raised <= '0;
            for (int i = 0; i < 16; i++) r_cnt[i] <= '0;
        end else if (i_cmd.execute) begin
            r_step <= n_step; r_rdy <= n_rdy; r_ris <= n_ris; r_aeoi <= n_aeoi;
            r_poll <= n_poll; r_rot <= n_rot; r_sfnm <= n_sfnm; r_smm <= n_smm;
            r_raised <= n_raised; r_base <= n_base; r_irr <= n_irr;
            r_isr <= n_isr; r_imr <= n_imr; r_low <= n_low; r_elcr <= n_elcr;
            r_cnt <= n_cnt;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_rd <= n_rd; r_st <= n_st; r_notify <= n_notify;
        end
        if (i_cmd.resolve) r_hold <= n_hold;
    end

    assign o_result.read_data      = r_rd;
    assign o_result.status         = r_st;
    assign o_result.cpu_notify     = r_notify;
    assign o_result.pending_valid  = r_hold.pv;
    assign o_result.pending_vector = r_hold.vec;

endmodule

// ===== design/cascaded_interrupt_controller.sv =====
`timescale 1ns / 1ps
// Each transaction is accepted with its state update, then the resolve state
// registers the master-then-slave priority resolution; the two run in
// sequence, and a new transaction is taken only as the result is taken.
// Reset: synchronous active-low; masks to all ones, state (not payload) to zero.
module cascaded_interrupt_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    cic_in_if.sink       i_in,
    cic_out_if.source    o_out
);

    cic_pkg::t_cmd w_cmd;
    logic          r_deliver_mode;

    // Delivery route only; no result field depends on it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_deliver_mode <= 1'b0;
        else if (i_cfg_we) r_deliver_mode <= i_cfg_wdata;
    end

    cic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    cic_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_in.data),
        .o_result (o_out.data)
    );

endmodule
